// File: design/aef_pkg.sv
// Shared types and constants for the adaptive exponential filter trigger.
package aef_pkg;

	// Default sizes handed to the top level
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int ALPHA_FRAC_DEF  = 16;

	// Fixed field and datapath widths
	localparam int TAU_W  = 32;
	localparam int DT_W   = 32;
	localparam int DEN_W  = 33;
	localparam int REM_W  = 35;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int IDX_W  = 3;

	localparam logic [TAU_W-1:0] TAU_RESET = 32'd159155;

	// Input item kinds
	localparam logic KIND_FILTER = 1'b0;
	localparam logic KIND_PRESET = 1'b1;

	// Register map, one 32-bit word per register
	typedef enum logic [IDX_W-1:0] {
		REG_TAU    = 3'd0,
		REG_BYPASS = 3'd1,
		REG_UTHR   = 3'd2,
		REG_LTHR   = 3'd3,
		REG_UCMP   = 3'd4,
		REG_LCMP   = 3'd5
	} reg_idx_t;

	// Trigger comparison codes
	typedef enum logic [1:0] {
		CMP_LT = 2'd0,
		CMP_GT = 2'd1,
		CMP_LE = 2'd2,
		CMP_GE = 2'd3
	} cmp_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEN,
		ST_DIV,
		ST_DIFF,
		ST_MUL,
		ST_ADD,
		ST_FIN
	} state_t;

	// Trigger result
	typedef struct packed {
		logic level;
		logic rising;
		logic falling;
	} trig_res_t;

endpackage

// File: design/aef_alu.sv
// Shared adder/subtractor used for denominator, division, difference, multiply and update steps.
module aef_alu #(
	parameter int W = 58
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] res
);

	assign res = a + (sub ? ~b : b) + W'(sub);

endmodule

// File: design/aef_trig.sv
// Schmitt trigger decision on the full-precision filter value.
module aef_trig #(
	parameter int SAMPLE_BITS = aef_pkg::SAMPLE_BITS_DEF,
	parameter int ALPHA_FRAC  = aef_pkg::ALPHA_FRAC_DEF
) (
	input  logic signed [SAMPLE_BITS+ALPHA_FRAC-1:0] value,
	input  logic signed [SAMPLE_BITS-1:0]            upper_thr,
	input  logic signed [SAMPLE_BITS-1:0]            lower_thr,
	input  aef_pkg::cmp_t                            upper_cmp,
	input  aef_pkg::cmp_t                            lower_cmp,
	input  logic                                     prev_level,
	output aef_pkg::trig_res_t                       res
);

	localparam int VW = SAMPLE_BITS + ALPHA_FRAC;

	logic signed [VW-1:0] upper_fx;
	logic signed [VW-1:0] lower_fx;
	logic                 set_hit;
	logic                 clr_hit;
	logic                 lvl;

	assign upper_fx = {upper_thr, {ALPHA_FRAC{1'b0}}};
	assign lower_fx = {lower_thr, {ALPHA_FRAC{1'b0}}};

	always_comb begin
		case (upper_cmp)
			aef_pkg::CMP_LT: set_hit = value <  upper_fx;
			aef_pkg::CMP_GT: set_hit = value >  upper_fx;
			aef_pkg::CMP_LE: set_hit = value <= upper_fx;
			aef_pkg::CMP_GE: set_hit = value >= upper_fx;
			default:         set_hit = 1'b0;
		endcase
		case (lower_cmp)
			aef_pkg::CMP_LT: clr_hit = value <  lower_fx;
			aef_pkg::CMP_GT: clr_hit = value >  lower_fx;
			aef_pkg::CMP_LE: clr_hit = value <= lower_fx;
			aef_pkg::CMP_GE: clr_hit = value >= lower_fx;
			default:         clr_hit = 1'b0;
		endcase
		// set wins over clear
		if (set_hit) begin
			lvl = 1'b1;
		end else if (clr_hit) begin
			lvl = 1'b0;
		end else begin
			lvl = prev_level;
		end
		res.level   = lvl;
		res.rising  = lvl & ~prev_level;
		res.falling = ~lvl & prev_level;
	end

endmodule

// File: design/adaptive_exponential_filter_trigger.sv
// Top level: first-order low-pass with time-adaptive alpha and Schmitt trigger output.
// Filter beat with elapsed_us > 0 and bypass off: the shared adder runs the denominator,
// the alpha divider, the difference, the shift-add multiply (ALPHA_FRAC+1 steps each for
// divider and multiply) and the update. Preset, bypass or zero elapsed go straight to finish.
// One beat in flight, in_stall high from accept until the result registers, so no new beat
// is taken before then, and a stalled output holds it back. arst_n clears state; regs take defaults.
module adaptive_exponential_filter_trigger #(
	parameter int SAMPLE_BITS = aef_pkg::SAMPLE_BITS_DEF,
	parameter int ALPHA_FRAC  = aef_pkg::ALPHA_FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB-style configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [aef_pkg::ADDR_W-1:0]        paddr,
	input  logic [aef_pkg::DATA_W-1:0]        pwdata,
	output logic [aef_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic [aef_pkg::DT_W-1:0]          elapsed_us,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [SAMPLE_BITS-1:0]     filtered,
	output logic                              level,
	output logic                              rising,
	output logic                              falling
);

	// Datapath widths
	localparam int VW    = SAMPLE_BITS + ALPHA_FRAC;   // filter value
	localparam int DW    = VW + 1;                     // target - value
	localparam int AQW   = ALPHA_FRAC + 1;             // alpha, 0 .. 1.0
	localparam int PW    = DW + AQW;                   // alpha * diff
	localparam int AW    = (PW > aef_pkg::REM_W) ? PW : aef_pkg::REM_W;
	localparam int CNT_W = $clog2(AQW);
	localparam int RW    = aef_pkg::REM_W;

	// ---------------- configuration registers ----------------
	logic [aef_pkg::TAU_W-1:0]     tau_q;
	logic                          bypass_q;
	logic signed [SAMPLE_BITS-1:0] upper_thr_q;
	logic signed [SAMPLE_BITS-1:0] lower_thr_q;
	aef_pkg::cmp_t                 upper_cmp_q;
	aef_pkg::cmp_t                 lower_cmp_q;
	aef_pkg::reg_idx_t             reg_idx;
	logic                          cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = aef_pkg::reg_idx_t'(paddr[aef_pkg::ADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q       <= aef_pkg::TAU_RESET;
			bypass_q    <= 1'b0;
			upper_thr_q <= '0;
			lower_thr_q <= '0;
			upper_cmp_q <= aef_pkg::CMP_GT;
			lower_cmp_q <= aef_pkg::CMP_LT;
		end else if (cfg_wr) begin
			case (reg_idx)
				aef_pkg::REG_TAU:    tau_q       <= pwdata;
				aef_pkg::REG_BYPASS: bypass_q    <= pwdata[0];
				aef_pkg::REG_UTHR:   upper_thr_q <= pwdata[SAMPLE_BITS-1:0];
				aef_pkg::REG_LTHR:   lower_thr_q <= pwdata[SAMPLE_BITS-1:0];
				aef_pkg::REG_UCMP:   upper_cmp_q <= aef_pkg::cmp_t'(pwdata[1:0]);
				aef_pkg::REG_LCMP:   lower_cmp_q <= aef_pkg::cmp_t'(pwdata[1:0]);
				default: ;  // unmapped words ignored
			endcase
		end
	end

	// read back, thresholds sign-extended
	always_comb begin
		case (reg_idx)
			aef_pkg::REG_TAU:    prdata = tau_q;
			aef_pkg::REG_BYPASS: prdata = aef_pkg::DATA_W'(bypass_q);
			aef_pkg::REG_UTHR:   prdata = aef_pkg::DATA_W'(upper_thr_q);
			aef_pkg::REG_LTHR:   prdata = aef_pkg::DATA_W'(lower_thr_q);
			aef_pkg::REG_UCMP:   prdata = aef_pkg::DATA_W'(upper_cmp_q);
			aef_pkg::REG_LCMP:   prdata = aef_pkg::DATA_W'(lower_cmp_q);
			default:             prdata = '0;
		endcase
	end

	// ---------------- sequencer and datapath registers ----------------
	aef_pkg::state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [aef_pkg::DT_W-1:0]      dt_q;
	logic [aef_pkg::DEN_W-1:0]     denom_q;   // tau + dt
	logic [RW-1:0]                 rem_q;     // divider partial remainder
	logic [AQW-1:0]                alpha_q;   // quotient, built MSB first
	logic signed [DW-1:0]          diff_q;
	logic signed [PW-1:0]          acc_q;     // shift-add product
	logic [CNT_W-1:0]              cnt_q;
	logic signed [VW-1:0]          value_q;   // filter state
	logic                          level_q;   // trigger state

	logic signed [SAMPLE_BITS-1:0] filtered_q;
	logic                          out_valid_q;
	logic                          level_out_q;
	logic                          rising_q;
	logic                          falling_q;

	logic                          in_acc;
	logic                          out_free;
	logic                          direct_load;
	logic signed [VW-1:0]          in_target;
	logic signed [VW-1:0]          target;

	// shared unit operands
	logic [AW-1:0] alu_a;
	logic [AW-1:0] alu_b;
	logic          alu_sub;
	logic [AW-1:0] alu_res;
	logic          div_take;
	logic [RW-1:0] rem_next;

	aef_pkg::trig_res_t trig;

	assign in_acc      = in_valid & ~in_stall;
	assign out_free    = ~out_valid_q | ~out_stall;
	assign direct_load = (kind == aef_pkg::KIND_PRESET) | bypass_q;
	assign in_target   = {sample, {ALPHA_FRAC{1'b0}}};
	assign target      = {sample_q, {ALPHA_FRAC{1'b0}}};

	// restoring divider: keep the difference when it is not negative
	assign div_take = ~alu_res[AW-1];
	assign rem_next = div_take ? alu_res[RW-1:0] : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aef_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state plus shared-unit operand selection
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		alu_a    = '0;
		alu_b    = '0;
		alu_sub  = 1'b0;
		case (state_q)
			aef_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (direct_load || elapsed_us == '0) begin
						state_d = aef_pkg::ST_FIN;
					end else begin
						state_d = aef_pkg::ST_DEN;
					end
				end
			end
			aef_pkg::ST_DEN: begin
				alu_a   = AW'(tau_q);
				alu_b   = AW'(dt_q);
				state_d = aef_pkg::ST_DIV;
			end
			aef_pkg::ST_DIV: begin
				alu_a   = AW'(rem_q);
				alu_b   = AW'(denom_q);
				alu_sub = 1'b1;
				if (cnt_q == '0) begin
					state_d = aef_pkg::ST_DIFF;
				end
			end
			aef_pkg::ST_DIFF: begin
				alu_a   = AW'(target);
				alu_b   = AW'(value_q);
				alu_sub = 1'b1;
				state_d = aef_pkg::ST_MUL;
			end
			aef_pkg::ST_MUL: begin
				alu_a = AW'(signed'({acc_q[PW-2:0], 1'b0}));
				alu_b = alpha_q[cnt_q] ? AW'(diff_q) : '0;
				if (cnt_q == '0) begin
					state_d = aef_pkg::ST_ADD;
				end
			end
			aef_pkg::ST_ADD: begin
				// floor(alpha * diff / 2^F) by arithmetic shift
				alu_a   = AW'(value_q);
				alu_b   = AW'(acc_q >>> ALPHA_FRAC);
				state_d = aef_pkg::ST_FIN;
			end
			aef_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = aef_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aef_pkg::ST_IDLE;
			end
		endcase
	end

	aef_alu #(
		.W (AW)
	) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res)
	);

	aef_trig #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.ALPHA_FRAC  (ALPHA_FRAC)
	) u_trig (
		.value      (value_q),
		.upper_thr  (upper_thr_q),
		.lower_thr  (lower_thr_q),
		.upper_cmp  (upper_cmp_q),
		.lower_cmp  (lower_cmp_q),
		.prev_level (level_q),
		.res        (trig)
	);

	// payload working registers
	always_ff @(posedge clk) begin
		case (state_q)
			aef_pkg::ST_IDLE: begin
				sample_q <= sample;
				dt_q     <= elapsed_us;
			end
			aef_pkg::ST_DEN: begin
				denom_q <= alu_res[aef_pkg::DEN_W-1:0];
				rem_q   <= RW'(dt_q);
				alpha_q <= '0;
				cnt_q   <= CNT_W'(ALPHA_FRAC);
			end
			aef_pkg::ST_DIV: begin
				alpha_q <= {alpha_q[AQW-2:0], div_take};
				rem_q   <= {rem_next[RW-2:0], 1'b0};
				cnt_q   <= cnt_q - 1'b1;
			end
			aef_pkg::ST_DIFF: begin
				diff_q <= alu_res[DW-1:0];
				acc_q  <= '0;
				cnt_q  <= CNT_W'(ALPHA_FRAC);
			end
			aef_pkg::ST_MUL: begin
				acc_q <= alu_res[PW-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	// filter and trigger state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			level_q <= 1'b0;
		end else begin
			if (in_acc && direct_load) begin
				value_q <= in_target;          // preset or bypass
			end else if (state_q == aef_pkg::ST_ADD) begin
				value_q <= alu_res[VW-1:0];
			end
			if (state_q == aef_pkg::ST_FIN && out_free) begin
				level_q <= trig.level;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == aef_pkg::ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == aef_pkg::ST_FIN && out_free) begin
			filtered_q  <= value_q[VW-1:ALPHA_FRAC];   // floor of the value
			level_out_q <= trig.level;
			rising_q    <= trig.rising;
			falling_q   <= trig.falling;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign level     = level_out_q;
	assign rising    = rising_q;
	assign falling   = falling_q;

	// ---------------- assertions ----------------
	// an accepted beat always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != aef_pkg::ST_IDLE))
		else $error("accepted beat did not start the sequencer");

	// a finished result waits while the output slot is held
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aef_pkg::ST_FIN && out_valid_q && out_stall)
		|=> (state_q == aef_pkg::ST_FIN))
		else $error("result left before output slot freed");

	// alpha never exceeds 1.0
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aef_pkg::ST_DIFF) |-> (alpha_q <= (AQW'(1) << ALPHA_FRAC)))
		else $error("alpha above one");

	// edges agree with level
	a_edge_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!(rising_q && falling_q) && (!rising_q || level_out_q)
			&& (!falling_q || !level_out_q)))
		else $error("edge flags inconsistent with level");

endmodule
